FILE: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and fixed constants for the epoch seconds to calendar date unit.
// ----------------------------------------------------------------------------
package esc_pkg;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    // seconds per day, split as 2^7 * 675
    localparam logic [16:0] C_SEC_PER_DAY  = 17'd86400;
    localparam int          C_DAY_PRESHIFT = 7;
    localparam logic [25:0] C_DAY_RECIP    = 26'd50903316;   // floor(2^35 / 675)
    localparam int          C_DAY_SHIFT    = 35;

    // seconds per hour, split as 2^4 * 225
    localparam logic [16:0] C_SEC_PER_HOUR = 17'd3600;
    localparam logic [12:0] C_HOUR_RECIP   = 13'd4660;       // floor(2^20 / 225)
    localparam int          C_HOUR_SHIFT   = 20;

    // seconds per minute, split as 2^2 * 15
    localparam logic [11:0] C_SEC_PER_MIN  = 12'd60;
    localparam logic [10:0] C_MIN_RECIP    = 11'd1092;       // floor(2^14 / 15)
    localparam int          C_MIN_SHIFT    = 14;

    // four year cycles counted from 1969-01-01
    localparam logic [15:0] C_CYCLE_DAYS   = 16'd1461;
    localparam logic [15:0] C_CYCLE_RECIP  = 16'd45933;      // floor(2^26 / 1461)
    localparam int          C_CYCLE_SHIFT  = 26;
    localparam logic [11:0] C_BASE_YEAR    = 12'd1969;
    localparam logic [8:0]  C_YEAR_DAYS    = 9'd365;

    // first day after 2100-02-28, counted from the epoch
    localparam logic [15:0] C_DAY_2100_MAR = 16'd47541;

    localparam logic [19:0] C_USEC_PER_SEC = 20'd1000000;

    // day of year at which each month starts, common year
    localparam logic [8:0] C_MONTH_START [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

endpackage

FILE: rtl/epoch_seconds_to_calendar_date_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_unit
// Unix time in seconds plus binary fraction to Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Raise start with i_whole_seconds and i_second_fraction; the item transfers
// at a clock edge where start is high and busy is low. busy is high only
// during reset and until the next clock edge after it, so the block takes a
// new item in every cycle.
// Each result appears on the o_ ports for one cycle with o_valid high, once
// its item has passed the pipeline. Throughput is one item per cycle; the
// pipeline is a chain of constant reciprocal multiplies (days, then four year
// cycles in parallel with hours and minutes), each followed by a one step
// correction stage.
// Reset clears the valid pipeline, so items in flight are dropped. The
// receiver cannot stall: results are never held back.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date_unit
    import esc_pkg::*;
#(
    parameter int FRACTION_BITS = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [31:0]              i_whole_seconds,
    input  logic [FRACTION_BITS-1:0] i_second_fraction,
    output logic                     o_valid,
    output logic [11:0]              o_year,
    output logic [3:0]               o_month,
    output logic [4:0]               o_day,
    output logic [4:0]               o_hour,
    output logic [5:0]               o_minute,
    output logic [5:0]               o_second,
    output logic [19:0]              o_microsecond,
    output logic                     o_has_fraction
);

    localparam int LAT = 8;
    localparam int MW  = FRACTION_BITS + 20;

    logic           r_busy;
    logic [LAT-1:0] r_vld;
    logic           w_take;

    assign w_take = start && !r_busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[LAT-2:0], w_take};
        end
    end

    // stage 1: day estimate product and microseconds
    logic [24:0]    w_dx;
    logic [50:0]    n1_prod;
    logic [MW-1:0]  n1_usec;
    logic [31:0]    r1_secs;
    logic [50:0]    r1_prod;

    logic [19:0]    r_usec_pipe [LAT];
    logic           r_frac_pipe [LAT];

    always_comb begin
        w_dx    = i_whole_seconds[31:C_DAY_PRESHIFT];
        n1_prod = {26'd0, w_dx} * {25'd0, C_DAY_RECIP};
        n1_usec = MW'(i_second_fraction) * MW'(C_USEC_PER_SEC);
    end

    always_ff @(posedge i_clk) begin
        r1_secs        <= i_whole_seconds;
        r1_prod        <= n1_prod;
        r_usec_pipe[0] <= n1_usec[MW-1:FRACTION_BITS];
        r_frac_pipe[0] <= (i_second_fraction != '0);
        for (int k = 1; k < LAT; k++) begin
            r_usec_pipe[k] <= r_usec_pipe[k-1];
            r_frac_pipe[k] <= r_frac_pipe[k-1];
        end
    end

    // stage 2: remainder against the estimated day count
    logic [15:0] n2_q;
    logic [32:0] n2_qmul;
    logic [32:0] n2_diff;
    logic [15:0] r2_q;
    logic [17:0] r2_rem;

    always_comb begin
        n2_q    = r1_prod[C_DAY_SHIFT+15:C_DAY_SHIFT];
        n2_qmul = {17'd0, n2_q} * {16'd0, C_SEC_PER_DAY};
        n2_diff = {1'b0, r1_secs} - n2_qmul;
    end

    always_ff @(posedge i_clk) begin
        r2_q   <= n2_q;
        r2_rem <= n2_diff[17:0];
    end

    // stage 3: correct the day count
    logic [15:0] r3_days;
    logic [16:0] r3_sod;

    always_ff @(posedge i_clk) begin
        if (r2_rem >= {1'b0, C_SEC_PER_DAY}) begin
            r3_days <= r2_q + 16'd1;
            r3_sod  <= 17'(r2_rem - {1'b0, C_SEC_PER_DAY});
        end else begin
            r3_days <= r2_q;
            r3_sod  <= r2_rem[16:0];
        end
    end

    t_date w_date;

    esc_calendar u_calendar (
        .i_clk  (i_clk),
        .i_days (r3_days),
        .o_date (w_date)
    );

    // time of day, five stages to line up with the calendar
    logic [25:0] r4_hprod;
    logic [16:0] r4_sod;

    always_ff @(posedge i_clk) begin
        r4_hprod <= {13'd0, r3_sod[16:4]} * {13'd0, C_HOUR_RECIP};
        r4_sod   <= r3_sod;
    end

    logic [4:0]  n5_h;
    logic [16:0] n5_hmul;
    logic [16:0] n5_diff;
    logic [4:0]  r5_h;
    logic [12:0] r5_rem;

    always_comb begin
        n5_h    = r4_hprod[C_HOUR_SHIFT+4:C_HOUR_SHIFT];
        n5_hmul = {12'd0, n5_h} * C_SEC_PER_HOUR;
        n5_diff = r4_sod - n5_hmul;
    end

    always_ff @(posedge i_clk) begin
        r5_h   <= n5_h;
        r5_rem <= n5_diff[12:0];
    end

    logic [4:0]  r6_hour;
    logic [11:0] r6_soh;

    always_ff @(posedge i_clk) begin
        if (r5_rem >= C_SEC_PER_HOUR[12:0]) begin
            r6_hour <= r5_h + 5'd1;
            r6_soh  <= 12'(r5_rem - C_SEC_PER_HOUR[12:0]);
        end else begin
            r6_hour <= r5_h;
            r6_soh  <= r5_rem[11:0];
        end
    end

    logic [20:0] r7_mprod;
    logic [11:0] r7_soh;
    logic [4:0]  r7_hour;

    always_ff @(posedge i_clk) begin
        r7_mprod <= {11'd0, r6_soh[11:2]} * {10'd0, C_MIN_RECIP};
        r7_soh   <= r6_soh;
        r7_hour  <= r6_hour;
    end

    logic [5:0]  n8_m;
    logic [11:0] n8_mmul;
    logic [6:0]  n8_rem;
    logic [5:0]  r8_minute;
    logic [5:0]  r8_second;
    logic [4:0]  r8_hour;

    always_comb begin
        n8_m    = r7_mprod[C_MIN_SHIFT+5:C_MIN_SHIFT];
        n8_mmul = {6'd0, n8_m} * C_SEC_PER_MIN;
        n8_rem  = 7'(r7_soh - n8_mmul);
    end

    always_ff @(posedge i_clk) begin
        r8_hour <= r7_hour;
        if (n8_rem >= C_SEC_PER_MIN[6:0]) begin
            r8_minute <= n8_m + 6'd1;
            r8_second <= 6'(n8_rem - C_SEC_PER_MIN[6:0]);
        end else begin
            r8_minute <= n8_m;
            r8_second <= n8_rem[5:0];
        end
    end

    assign o_valid        = r_vld[LAT-1];
    assign o_year         = w_date.year;
    assign o_month        = w_date.month;
    assign o_day          = w_date.day;
    assign o_hour         = r8_hour;
    assign o_minute       = r8_minute;
    assign o_second       = r8_second;
    assign o_microsecond  = r_usec_pipe[LAT-1];
    assign o_has_fraction = r_frac_pipe[LAT-1];

endmodule

FILE: rtl/esc_calendar.sv
// ----------------------------------------------------------------------------
// esc_calendar
// Five stage pipeline from days since the epoch to year, month and day.
// ----------------------------------------------------------------------------
module esc_calendar
    import esc_pkg::*;
(
    input  logic        i_clk,
    input  logic [15:0] i_days,
    output t_date       o_date
);

    // stage 1: shift to a 1969 origin, 2100 is not a leap year so skip its feb 29
    logic [15:0] n1_t;
    logic [31:0] n1_prod;
    logic [15:0] r1_t;
    logic [31:0] r1_prod;

    always_comb begin
        n1_t    = i_days + ((i_days >= C_DAY_2100_MAR) ? 16'd366 : 16'd365);
        n1_prod = {16'd0, n1_t} * {16'd0, C_CYCLE_RECIP};
    end

    always_ff @(posedge i_clk) begin
        r1_t    <= n1_t;
        r1_prod <= n1_prod;
    end

    // stage 2: estimated cycle count and remainder
    logic [5:0]  n2_cyc;
    logic [16:0] n2_cmul;
    logic [16:0] n2_diff;
    logic [5:0]  r2_cyc;
    logic [11:0] r2_rem;

    always_comb begin
        n2_cyc  = r1_prod[C_CYCLE_SHIFT+5:C_CYCLE_SHIFT];
        n2_cmul = {11'd0, n2_cyc} * {1'b0, C_CYCLE_DAYS};
        n2_diff = {1'b0, r1_t} - n2_cmul;
    end

    always_ff @(posedge i_clk) begin
        r2_cyc <= n2_cyc;
        r2_rem <= n2_diff[11:0];
    end

    // stage 3: estimate is low by at most one
    logic [5:0]  r3_cyc;
    logic [10:0] r3_rem;

    always_ff @(posedge i_clk) begin
        if (r2_rem >= C_CYCLE_DAYS[11:0]) begin
            r3_cyc <= r2_cyc + 6'd1;
            r3_rem <= 11'(r2_rem - C_CYCLE_DAYS[11:0]);
        end else begin
            r3_cyc <= r2_cyc;
            r3_rem <= r2_rem[10:0];
        end
    end

    // stage 4: year within the cycle, last year of a cycle is the leap one
    logic [1:0]  n4_yy;
    logic [10:0] n4_sub;
    logic [11:0] r4_year;
    logic [8:0]  r4_doy;
    logic        r4_leap;

    always_comb begin
        if (r3_rem >= 11'd1095) begin
            n4_yy  = 2'd3;
            n4_sub = 11'd1095;
        end else if (r3_rem >= 11'd730) begin
            n4_yy  = 2'd2;
            n4_sub = 11'd730;
        end else if (r3_rem >= 11'(C_YEAR_DAYS)) begin
            n4_yy  = 2'd1;
            n4_sub = 11'(C_YEAR_DAYS);
        end else begin
            n4_yy  = 2'd0;
            n4_sub = 11'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_year <= C_BASE_YEAR + {4'd0, r3_cyc, 2'b00} + {10'd0, n4_yy};
        r4_doy  <= 9'(r3_rem - n4_sub);
        r4_leap <= (n4_yy == 2'd3);
    end

    // stage 5: month and day of month
    logic [3:0] n5_month;
    logic [8:0] n5_base;
    logic [8:0] n5_off;

    always_comb begin
        logic [8:0] thr;
        n5_month = 4'd1;
        n5_base  = 9'd0;
        for (int k = 1; k < 12; k++) begin
            thr = C_MONTH_START[k] + ((r4_leap && (k >= 2)) ? 9'd1 : 9'd0);
            if (r4_doy >= thr) begin
                n5_month = 4'(k + 1);
                n5_base  = thr;
            end
        end
        n5_off = r4_doy - n5_base;
    end

    always_ff @(posedge i_clk) begin
        o_date.year  <= r4_year;
        o_date.month <= n5_month;
        o_date.day   <= n5_off[4:0] + 5'd1;
    end

endmodule
